@@ rtl/ale_pkg.sv @@
package ale_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int STAT_W       = 3;
  localparam int OP_W         = 3;
  localparam int CAPACITY_DEF = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd5;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd4;

  // sequencer steps
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_EMIT1, S_POP, S_SRCH, S_UPD,
    S_FIN, S_READ, S_INS, S_PUT, S_DEL, S_DELFIN
  } step_t;

  // datapath actions
  typedef enum logic [3:0] {
    A_NOP, A_DECODE, A_STAT, A_POP, A_SRCH, A_UPD,
    A_FIN, A_READ, A_SHUP, A_PUT, A_SHDN, A_DELFIN
  } act_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NONE, C_START, C_DISPATCH, C_END, C_EQPOS, C_EQCNT
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  // control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_IDLE:     w = '{A_NOP,    C_START,    S_DISPATCH, S_IDLE};
      S_DISPATCH: w = '{A_DECODE, C_DISPATCH, S_IDLE,     S_IDLE};
      S_EMIT1:    w = '{A_STAT,   C_NONE,     S_IDLE,     S_IDLE};
      S_POP:      w = '{A_POP,    C_NONE,     S_IDLE,     S_IDLE};
      S_SRCH:     w = '{A_SRCH,   C_END,      S_FIN,      S_SRCH};
      S_UPD:      w = '{A_UPD,    C_END,      S_FIN,      S_UPD};
      S_FIN:      w = '{A_FIN,    C_NONE,     S_IDLE,     S_IDLE};
      S_READ:     w = '{A_READ,   C_END,      S_IDLE,     S_READ};
      S_INS:      w = '{A_SHUP,   C_EQPOS,    S_PUT,      S_INS};
      S_PUT:      w = '{A_PUT,    C_NONE,     S_IDLE,     S_IDLE};
      S_DEL:      w = '{A_SHDN,   C_EQCNT,    S_DELFIN,   S_DEL};
      S_DELFIN:   w = '{A_DELFIN, C_NONE,     S_IDLE,     S_IDLE};
      default:    w = '{A_NOP,    C_NONE,     S_IDLE,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/array_list_engine_unit.sv @@
// bounded ordered list of signed words, driven by a microcoded step sequencer
// operations that do not walk the list pass from the dispatch step to a result step, whose output is registered
// search, update, read-out and shifts walk the list one entry per cycle through the one memory read port
// read-out gives one result per cycle; busy stays high until the final result is issued
// reset (synchronous, active high) empties the list; the receiver cannot stall results
module array_list_engine_unit
  import ale_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          op,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic [POS_W-1:0]         position,
  output logic                     valid,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] value_res,
  output logic [POS_W-1:0]         position_res,
  output logic                     last
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // sequencer and list state
  step_t            step, step_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic             pend, pend_next;
  logic [POS_W-1:0] pend_pos, pend_pos_next;
  logic [STAT_W-1:0] stat, stat_next;

  // latched command
  logic [OP_W-1:0]          op_q;
  logic signed [DATA_W-1:0] value_q, nval_q;
  logic [POS_W-1:0]         pos_q;

  // result register inputs
  logic                     valid_next, last_next;
  logic [STAT_W-1:0]        status_next;
  logic signed [DATA_W-1:0] value_res_next;
  logic [POS_W-1:0]         position_res_next;

  // element memory
  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata;
  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic signed [DATA_W-1:0] wdata;

  uword_t           uw;
  logic             take, jump, full, empty, match;
  logic [CNT_W-1:0] ptr_inc, ptr_dec, last_idx;
  logic [CMP_W-1:0] pos_ext, count_ext;
  step_t            disp_step;
  logic [STAT_W-1:0] disp_stat;

  assign busy     = (step != S_IDLE);
  assign take     = start && !busy;
  assign uw       = ucode(step);
  assign full     = (count >= CAP_C);
  assign empty    = (count == '0);
  assign match    = (rdata == value_q);
  assign ptr_inc  = ptr + CNT_W'(1);
  assign ptr_dec  = ptr - CNT_W'(1);
  assign last_idx = count - CNT_W'(1);
  assign pos_ext   = CMP_W'(pos_q);
  assign count_ext = CMP_W'(count);

  // operation dispatch: error cases go straight to a single status result
  always_comb begin
    disp_step = S_EMIT1;
    disp_stat = ST_OK;
    if (op_q == OP_APPEND) begin
      disp_stat = full ? ST_FULL : ST_OK;
    end else if (op_q == OP_INSERT && full) begin
      disp_stat = ST_FULL;
    end else if (op_q == OP_REMOVE || op_q == OP_SEARCH || op_q == OP_UPDATE ||
                 op_q == OP_READ || op_q == OP_INSERT || op_q == OP_DELETE) begin
      if (empty) begin
        disp_stat = ST_EMPTY;
      end else begin
        case (op_q)
          OP_REMOVE: disp_step = S_POP;
          OP_SEARCH: disp_step = S_SRCH;
          OP_UPDATE: disp_step = S_UPD;
          OP_READ:   disp_step = S_READ;
          OP_INSERT: begin
            if (pos_ext >= count_ext) disp_stat = ST_BADPOS;
            else disp_step = S_INS;
          end
          default: begin
            if (pos_ext == '0 || pos_ext > count_ext) disp_stat = ST_BADPOS;
            else disp_step = S_DEL;
          end
        endcase
      end
    end
  end

  // jump condition for the current control word
  always_comb begin
    case (uw.cond)
      C_START: jump = take;
      C_END:   jump = (ptr == last_idx);
      C_EQPOS: jump = (CMP_W'(ptr) == pos_ext);
      C_EQCNT: jump = (ptr == count);
      default: jump = 1'b0;
    endcase
  end

  // datapath driven by the control word
  always_comb begin
    step_next         = jump ? uw.jmp : uw.nxt;
    count_next        = count;
    ptr_next          = ptr;
    pend_next         = pend;
    pend_pos_next     = pend_pos;
    stat_next         = stat;
    we                = 1'b0;
    waddr             = ptr[AW-1:0];
    wdata             = rdata;
    valid_next        = 1'b0;
    last_next         = 1'b1;
    status_next       = ST_OK;
    value_res_next    = '0;
    position_res_next = '0;
    case (uw.act)
      A_DECODE: begin
        step_next     = disp_step;
        stat_next     = disp_stat;
        pend_next     = 1'b0;
        pend_pos_next = '0;
        case (disp_step)
          S_POP, S_INS: ptr_next = last_idx;
          S_DEL:        ptr_next = CNT_W'(pos_ext);
          default:      ptr_next = '0;
        endcase
        // append writes at the fill count
        if (op_q == OP_APPEND && !full) begin
          we         = 1'b1;
          waddr      = count[AW-1:0];
          wdata      = value_q;
          count_next = count + CNT_W'(1);
        end
      end
      A_STAT: begin
        valid_next  = 1'b1;
        status_next = stat;
      end
      A_POP: begin
        valid_next     = 1'b1;
        value_res_next = rdata;
        count_next     = last_idx;
      end
      A_SRCH: begin
        // each match is held back until the next match or the end of the walk so the final one can carry last
        ptr_next = ptr_inc;
        if (match) begin
          if (pend) begin
            valid_next        = 1'b1;
            last_next         = 1'b0;
            position_res_next = pend_pos;
          end
          pend_next     = 1'b1;
          pend_pos_next = POS_W'(ptr_inc);
        end
      end
      A_UPD: begin
        ptr_next = ptr_inc;
        if (match) begin
          we        = 1'b1;
          wdata     = nval_q;
          pend_next = 1'b1;
        end
      end
      A_FIN: begin
        valid_next        = 1'b1;
        status_next       = pend ? ST_OK : ST_NOTFOUND;
        position_res_next = pend_pos;
      end
      A_READ: begin
        valid_next        = 1'b1;
        last_next         = jump;
        value_res_next    = rdata;
        position_res_next = POS_W'(ptr_inc);
        ptr_next          = ptr_inc;
      end
      A_SHUP: begin
        we    = 1'b1;
        waddr = ptr_inc[AW-1:0];
        if (!jump) ptr_next = ptr_dec;
      end
      A_PUT: begin
        we          = 1'b1;
        waddr       = AW'(pos_ext);
        wdata       = value_q;
        count_next  = count + CNT_W'(1);
        valid_next  = 1'b1;
      end
      A_SHDN: begin
        if (!jump) begin
          we       = 1'b1;
          waddr    = ptr_dec[AW-1:0];
          ptr_next = ptr_inc;
        end
      end
      A_DELFIN: begin
        count_next = last_idx;
        valid_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // read address follows the next pointer so rdata holds the entry at ptr
  assign raddr = (ptr_next < CAP_C) ? ptr_next[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (we && waddr == raddr) rdata <= wdata;
    else rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= S_IDLE;
      count <= '0;
      valid <= 1'b0;
    end else begin
      step  <= step_next;
      count <= count_next;
      valid <= valid_next;
    end
    ptr          <= ptr_next;
    pend         <= pend_next;
    pend_pos     <= pend_pos_next;
    stat         <= stat_next;
    status       <= status_next;
    value_res    <= value_res_next;
    position_res <= position_res_next;
    last         <= last_next;
    // command capture on the start transfer
    if (take) begin
      op_q    <= op;
      value_q <= value;
      nval_q  <= new_value;
      pos_q   <= position;
    end
  end

endmodule
